FILE: src/bc_pkg.sv
// shared widths and defaults for the betweenness centrality block
package bc_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_EDGES    = 1024;
	localparam int DEF_FRAC_BITS    = 20;

	localparam int VID_W   = 6;   // vertex identifier
	localparam int CNT_W   = 7;   // vertex count and vertex counters
	localparam int DIST_W  = 7;   // hop distance
	localparam int SIGMA_W = 48;  // shortest path count
	localparam int CENT_W  = 32;  // dependency and centrality
	localparam int MULB_W  = 33;  // one plus dependency

	localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

endpackage

FILE: src/betweenness_centrality.sv
// betweenness centrality of a small directed graph, iterative shared arithmetic unit
//
// edges arrive as requests, one per cycle while busy is low, and are kept in an edge store
// of MAX_EDGES entries (later edges are dropped once it is full). the request marked by
// last_edge raises busy and starts the computation: every vertex in turn is the source of a
// breadth-first search that counts shortest paths, after which the visit order is walked
// backwards and dependencies are accumulated into each non-source vertex's centrality.
// every visited vertex scans the whole edge store in each direction; each shortest-path
// predecessor term is then computed in the one shared multiply/divide unit (33 shift-add
// steps, then 81 restoring divide steps). a final pass over the edges finds the vertices
// with out-edges, then one result per vertex is shown on the result ports, marked by
// result_strobe for one cycle each. results cannot be held off by the receiver and must
// be taken as they come. busy falls as the last result is shown. there is no clearing
// pass after reset. vertex_count may only be written while busy is low.
module betweenness_centrality #(
	parameter int MAX_VERTICES = bc_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = bc_pkg::DEF_MAX_EDGES,
	parameter int FRAC_BITS    = bc_pkg::DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bc_pkg::CNT_W-1:0]    cfg_wr_data,
	input  logic                        start,
	output logic                        busy,
	input  logic [bc_pkg::VID_W-1:0]    edge_source,
	input  logic [bc_pkg::VID_W-1:0]    edge_target,
	input  logic                        last_edge,
	output logic                        result_strobe,
	output logic [bc_pkg::VID_W-1:0]    vertex,
	output logic [bc_pkg::CENT_W-1:0]   centrality,
	output logic                        has_out_edges,
	output logic                        last_vertex
);
	import bc_pkg::*;

	localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int P_W = SIGMA_W + MULB_W;
	localparam int K_W = $clog2(P_W + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_SRC_INIT,
		S_F_HEAD, S_F_V, S_F_VD, S_F_E, S_F_EC, S_F_W,
		S_B_HEAD, S_B_V, S_B_VD, S_B_E, S_B_EC, S_B_P, S_MUL, S_DIV, S_B_UPD,
		S_B_ACC, S_B_CW,
		S_H_E, S_H_EC, S_O_RD, S_O_EM
	} state_t;

	state_t state_q;

	// configuration and control registers
	logic [CNT_W-1:0]        vcount_q;
	logic [CNT_W-1:0]        n_q;
	logic [EW-1:0]           cnt_q;
	logic [EW-1:0]           e_q;
	logic [CNT_W-1:0]        src_q, head_q, tail_q, ov_q;
	logic [VID_W-1:0]        v_q, w_q, p_q;
	logic [DIST_W-1:0]       dist_v_q;
	logic [SIGMA_W-1:0]      sigma_v_q;
	logic [CENT_W-1:0]       delta_v_q, delta_p_q;
	logic [MAX_VERTICES-1:0] reached_q, dvalid_q, cvalid_q, hasout_q;

	// shared multiply/divide unit
	logic [K_W-1:0]     step_q;
	logic [P_W-1:0]     prod_q;
	logic [SIGMA_W:0]   rem_q;
	logic [SIGMA_W-1:0] mul_a_q, div_d_q;

	// memories
	logic [VID_W-1:0]   es_mem [MAX_EDGES];
	logic [VID_W-1:0]   ee_mem [MAX_EDGES];
	logic [VID_W-1:0]   visit_mem [MAX_VERTICES];
	logic [DIST_W-1:0]  dist_mem [MAX_VERTICES];
	logic [SIGMA_W-1:0] sigma_mem [MAX_VERTICES];
	logic [CENT_W-1:0]  delta_mem [MAX_VERTICES];
	logic [CENT_W-1:0]  cacc_mem [MAX_VERTICES];

	logic [VID_W-1:0]   es_rd, ee_rd, visit_rd;
	logic [DIST_W-1:0]  dist_rd;
	logic [SIGMA_W-1:0] sigma_rd;
	logic [CENT_W-1:0]  delta_rd, cacc_rd;

	logic               accept, edge_we, edge_done;
	logic [CNT_W-1:0]   n_eff;
	logic [VID_W-1:0]   vx_ra, visit_ra, visit_wd;
	logic               visit_we, dist_we, sigma_we;
	logic [VID_W-1:0]   visit_wa, vx_wa;
	logic [DIST_W-1:0]  dist_wd, dist_v1;
	logic [SIGMA_W-1:0] sigma_wd, sigma_w_base;
	logic [SIGMA_W:0]   sigma_sum;
	logic               w_reached, on_path;
	logic [SIGMA_W:0]   mul_sum, div_r2;
	logic               div_ge;
	logic [CENT_W-1:0]  term, delta_new, cacc_new, cacc_base;
	logic [CENT_W:0]    delta_sum, cacc_sum;
	logic [MULB_W-1:0]  mul_b;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign edge_we   = accept && (cnt_q < EW'(MAX_EDGES));
	assign edge_done = ((e_q + EW'(1)) == cnt_q);

	// vertex_count 0 acts as 1, above the store size as the store size
	always_comb begin
		if (vcount_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (vcount_q > CNT_W'(MAX_VERTICES)) begin
			n_eff = CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = vcount_q;
		end
	end

	// forward relaxation of one edge v->w
	assign dist_v1      = dist_v_q + DIST_W'(1);
	assign w_reached    = reached_q[w_q[VW-1:0]];
	assign on_path      = !w_reached || (dist_rd == dist_v1);
	assign sigma_w_base = w_reached ? sigma_rd : '0;
	assign sigma_sum    = {1'b0, sigma_w_base} + {1'b0, sigma_v_q};

	// shift-add multiply step and restoring divide step
	assign mul_sum = {1'b0, prod_q[P_W-1:MULB_W]} + (prod_q[0] ? {1'b0, mul_a_q} : '0);
	assign div_r2  = {rem_q[SIGMA_W-1:0], prod_q[P_W-1]};
	assign div_ge  = (div_r2 >= {1'b0, div_d_q});
	assign mul_b   = (MULB_W'(1) << FRAC_BITS) + MULB_W'(delta_v_q);

	// quotient saturates at the accumulator ceiling; a zero divisor gives zero
	always_comb begin
		if (div_d_q == '0) begin
			term = '0;
		end else if (|prod_q[P_W-1:CENT_W]) begin
			term = '1;
		end else begin
			term = prod_q[CENT_W-1:0];
		end
	end
	assign delta_sum = {1'b0, delta_p_q} + {1'b0, term};
	assign delta_new = delta_sum[CENT_W] ? '1 : delta_sum[CENT_W-1:0];
	assign cacc_base = cvalid_q[v_q[VW-1:0]] ? cacc_rd : '0;
	assign cacc_sum  = {1'b0, cacc_base} + {1'b0, delta_v_q};
	assign cacc_new  = cacc_sum[CENT_W] ? '1 : cacc_sum[CENT_W-1:0];

	// memory port steering
	always_comb begin
		visit_ra = head_q[VID_W-1:0];
		vx_ra    = v_q;
		visit_we = 1'b0;
		visit_wa = tail_q[VID_W-1:0];
		visit_wd = w_q;
		dist_we  = 1'b0;
		sigma_we = 1'b0;
		vx_wa    = w_q;
		dist_wd  = dist_v1;
		sigma_wd = sigma_sum[SIGMA_W] ? '1 : sigma_sum[SIGMA_W-1:0];
		case (state_q)
			S_SRC_INIT: begin
				visit_we = 1'b1;
				visit_wa = '0;
				visit_wd = src_q[VID_W-1:0];
				dist_we  = 1'b1;
				sigma_we = 1'b1;
				vx_wa    = src_q[VID_W-1:0];
				dist_wd  = '0;
				sigma_wd = SIGMA_W'(1);
			end
			S_F_V, S_B_V: begin
				vx_ra = visit_rd;
			end
			S_F_EC: begin
				vx_ra = ee_rd;
			end
			S_B_EC: begin
				vx_ra = es_rd;
			end
			S_B_HEAD: begin
				visit_ra = VID_W'(tail_q - CNT_W'(1));
			end
			S_O_RD: begin
				vx_ra = ov_q[VID_W-1:0];
			end
			S_F_W: begin
				visit_we = !w_reached && (tail_q < CNT_W'(MAX_VERTICES));
				dist_we  = !w_reached;
				sigma_we = on_path;
			end
			default: begin
			end
		endcase
	end

	// edge store
	always_ff @(posedge clk) begin
		if (edge_we) begin
			es_mem[cnt_q[AW-1:0]] <= edge_source;
			ee_mem[cnt_q[AW-1:0]] <= edge_target;
		end
		es_rd <= es_mem[e_q[AW-1:0]];
		ee_rd <= ee_mem[e_q[AW-1:0]];
	end

	// per vertex stores
	always_ff @(posedge clk) begin
		if (visit_we) begin
			visit_mem[visit_wa[VW-1:0]] <= visit_wd;
		end
		visit_rd <= visit_mem[visit_ra[VW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[vx_wa[VW-1:0]] <= dist_wd;
		end
		if (sigma_we) begin
			sigma_mem[vx_wa[VW-1:0]] <= sigma_wd;
		end
		dist_rd  <= dist_mem[vx_ra[VW-1:0]];
		sigma_rd <= sigma_mem[vx_ra[VW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_B_UPD) begin
			delta_mem[p_q[VW-1:0]] <= delta_new;
		end
		delta_rd <= delta_mem[vx_ra[VW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_B_CW) begin
			cacc_mem[v_q[VW-1:0]] <= cacc_new;
		end
		cacc_rd <= cacc_mem[vx_ra[VW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			vcount_q      <= VCOUNT_RESET;
			cnt_q         <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (edge_we) begin
							cnt_q <= cnt_q + EW'(1);
						end
						if (last_edge) begin
							n_q      <= n_eff;
							src_q    <= '0;
							cvalid_q <= '0;
							hasout_q <= '0;
							state_q  <= S_SRC_INIT;
						end
					end
				end
				S_SRC_INIT: begin
					// only the source starts out reached
					reached_q <= MAX_VERTICES'(1) << src_q[VW-1:0];
					dvalid_q  <= '0;
					head_q    <= '0;
					tail_q    <= CNT_W'(1);
					state_q   <= S_F_HEAD;
				end
				// breadth-first search
				S_F_HEAD: begin
					state_q <= (head_q == tail_q) ? S_B_HEAD : S_F_V;
				end
				S_F_V: begin
					v_q     <= visit_rd;
					head_q  <= head_q + CNT_W'(1);
					state_q <= S_F_VD;
				end
				S_F_VD: begin
					dist_v_q  <= dist_rd;
					sigma_v_q <= sigma_rd;
					e_q       <= '0;
					state_q   <= S_F_E;
				end
				S_F_E: begin
					state_q <= S_F_EC;
				end
				S_F_EC: begin
					w_q <= ee_rd;
					if (es_rd == v_q && {1'b0, es_rd} < n_q && {1'b0, ee_rd} < n_q) begin
						state_q <= S_F_W;
					end else begin
						e_q     <= e_q + EW'(1);
						state_q <= edge_done ? S_F_HEAD : S_F_E;
					end
				end
				S_F_W: begin
					if (!w_reached) begin
						reached_q[w_q[VW-1:0]] <= 1'b1;
						if (tail_q < CNT_W'(MAX_VERTICES)) begin
							tail_q <= tail_q + CNT_W'(1);
						end
					end
					e_q     <= e_q + EW'(1);
					state_q <= edge_done ? S_F_HEAD : S_F_E;
				end
				// reverse walk over the visit order
				S_B_HEAD: begin
					if (tail_q == '0) begin
						src_q   <= src_q + CNT_W'(1);
						e_q     <= '0;
						state_q <= ((src_q + CNT_W'(1)) == n_q) ? S_H_E : S_SRC_INIT;
					end else begin
						tail_q  <= tail_q - CNT_W'(1);
						state_q <= S_B_V;
					end
				end
				S_B_V: begin
					v_q     <= visit_rd;
					state_q <= S_B_VD;
				end
				S_B_VD: begin
					dist_v_q  <= dist_rd;
					sigma_v_q <= sigma_rd;
					delta_v_q <= dvalid_q[v_q[VW-1:0]] ? delta_rd : '0;
					e_q       <= '0;
					state_q   <= S_B_E;
				end
				S_B_E: begin
					state_q <= S_B_EC;
				end
				S_B_EC: begin
					p_q <= es_rd;
					if (ee_rd == v_q && {1'b0, es_rd} < n_q && {1'b0, ee_rd} < n_q
							&& reached_q[es_rd[VW-1:0]]) begin
						state_q <= S_B_P;
					end else begin
						e_q     <= e_q + EW'(1);
						state_q <= edge_done ? S_B_ACC : S_B_E;
					end
				end
				S_B_P: begin
					if (dist_v_q == dist_rd + DIST_W'(1)) begin
						mul_a_q   <= sigma_rd;
						div_d_q   <= sigma_v_q;
						delta_p_q <= dvalid_q[p_q[VW-1:0]] ? delta_rd : '0;
						prod_q    <= P_W'(mul_b);
						step_q    <= '0;
						state_q   <= S_MUL;
					end else begin
						e_q     <= e_q + EW'(1);
						state_q <= edge_done ? S_B_ACC : S_B_E;
					end
				end
				S_MUL: begin
					prod_q <= {mul_sum, prod_q[MULB_W-1:1]};
					if (step_q == K_W'(MULB_W - 1)) begin
						step_q  <= '0;
						rem_q   <= '0;
						state_q <= S_DIV;
					end else begin
						step_q <= step_q + K_W'(1);
					end
				end
				S_DIV: begin
					prod_q <= {prod_q[P_W-2:0], div_ge};
					rem_q  <= div_ge ? (div_r2 - {1'b0, div_d_q}) : div_r2;
					if (step_q == K_W'(P_W - 1)) begin
						state_q <= S_B_UPD;
					end else begin
						step_q <= step_q + K_W'(1);
					end
				end
				S_B_UPD: begin
					dvalid_q[p_q[VW-1:0]] <= 1'b1;
					e_q                   <= e_q + EW'(1);
					state_q               <= edge_done ? S_B_ACC : S_B_E;
				end
				S_B_ACC: begin
					state_q <= (v_q == src_q[VID_W-1:0]) ? S_B_HEAD : S_B_CW;
				end
				S_B_CW: begin
					cvalid_q[v_q[VW-1:0]] <= 1'b1;
					state_q               <= S_B_HEAD;
				end
				// out-edge flags
				S_H_E: begin
					state_q <= S_H_EC;
				end
				S_H_EC: begin
					if ({1'b0, es_rd} < n_q && {1'b0, ee_rd} < n_q) begin
						hasout_q[es_rd[VW-1:0]] <= 1'b1;
					end
					e_q <= e_q + EW'(1);
					if (edge_done) begin
						ov_q    <= '0;
						state_q <= S_O_RD;
					end else begin
						state_q <= S_H_E;
					end
				end
				// one result per vertex
				S_O_RD: begin
					state_q <= S_O_EM;
				end
				S_O_EM: begin
					result_strobe <= 1'b1;
					vertex        <= ov_q[VID_W-1:0];
					centrality    <= cvalid_q[ov_q[VW-1:0]] ? cacc_rd : '0;
					has_out_edges <= hasout_q[ov_q[VW-1:0]];
					last_vertex   <= ((ov_q + CNT_W'(1)) == n_q);
					ov_q          <= ov_q + CNT_W'(1);
					if ((ov_q + CNT_W'(1)) == n_q) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_O_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// an edge that is not the last one never starts the computation
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last_edge) |=> !busy)
		else $error("busy raised by an edge that is not the last");

	// every result except the final one is shown while the block is still computing
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_vertex) |-> busy)
		else $error("result shown outside a computation");

	// nothing follows the final result
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_vertex) |=> !result_strobe)
		else $error("result after the final vertex");

	// results never come back to back
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("results on adjacent cycles");
`endif

endmodule

FILE: bench/bc_checker.sv
// checker: predicts per-vertex centrality from observed edge requests and compares results
`timescale 1ns / 1ps

module bc_checker #(
	parameter int MAX_EDGES = bc_pkg::DEF_MAX_EDGES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bc_pkg::CNT_W-1:0]   cfg_wr_data,
	input  logic                       start,
	input  logic                       busy,
	input  logic [bc_pkg::VID_W-1:0]   edge_source,
	input  logic [bc_pkg::VID_W-1:0]   edge_target,
	input  logic                       last_edge,
	input  logic                       result_strobe,
	input  logic [bc_pkg::VID_W-1:0]   vertex,
	input  logic [bc_pkg::CENT_W-1:0]  centrality,
	input  logic                       has_out_edges,
	input  logic                       last_vertex,
	output int                         outstanding,
	output int                         fail_count
);

	localparam int NV = bc_pkg::DEF_MAX_VERTICES;
	localparam int NE = MAX_EDGES;
	localparam logic [63:0] PATH_CAP = (64'd1 << bc_pkg::SIGMA_W) - 1;
	localparam logic [64:0] CENT_CAP = 65'hFFFF_FFFF;

	typedef struct packed {
		logic [bc_pkg::VID_W-1:0]  vid;
		logic [bc_pkg::CENT_W-1:0] cent;
		logic                      out_arcs;
		logic                      final_vid;
	} vertex_score_t;

	vertex_score_t expected_scores[$];

	logic [bc_pkg::CNT_W-1:0] vcount;
	logic [5:0]  arc_from [NE];
	logic [5:0]  arc_to   [NE];
	int          arcs_held;

	logic [31:0] score [NV];
	bit          seen  [NV];
	int          hops  [NV];
	logic [63:0] paths [NV];
	logic [31:0] dep   [NV];
	int          order [NV];

	assign outstanding = expected_scores.size();

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	// capped add into a 32 bit accumulator
	function automatic logic [31:0] add_capped(input logic [31:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {33'd0, a} + {1'b0, b};
		return (s > CENT_CAP) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic search_from(input int src, input int n);
		int head, tail, v, p, w, e;
		logic [127:0] prod, quo;
		logic [63:0] term, ps;
		head = 0;
		tail = 0;
		for (int i = 0; i < n; i++) begin
			seen[i] = 0;
			hops[i] = 0;
			paths[i] = 0;
			dep[i] = 0;
		end
		seen[src] = 1;
		paths[src] = 1;
		order[tail++] = src;
		// forward sweep counting shortest paths
		while (head < tail) begin
			v = order[head++];
			for (e = 0; e < arcs_held; e++) begin
				if (arc_from[e] != v || arc_from[e] >= n || arc_to[e] >= n)
					continue;
				w = arc_to[e];
				if (!seen[w]) begin
					seen[w] = 1;
					hops[w] = hops[v] + 1;
					if (tail < NV)
						order[tail++] = w;
				end
				if (hops[w] == hops[v] + 1) begin
					ps = paths[w] + paths[v];
					paths[w] = (ps > PATH_CAP) ? PATH_CAP : ps;
				end
			end
		end
		// backward sweep accumulating dependencies
		while (tail > 0) begin
			v = order[--tail];
			for (e = 0; e < arcs_held; e++) begin
				p = arc_from[e];
				if (arc_to[e] != v || p >= n || arc_to[e] >= n || !seen[p])
					continue;
				if (hops[v] == hops[p] + 1) begin
					prod = {64'd0, paths[p]} *
						({96'd0, dep[v]} + (128'd1 << bc_pkg::DEF_FRAC_BITS));
					quo = prod / {64'd0, paths[v]};
					term = (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
					dep[p] = add_capped(dep[p], term);
				end
			end
			if (v != src)
				score[v] = add_capped(score[v], {32'd0, dep[v]});
		end
	endtask

	task automatic predict_scores();
		int n;
		vertex_score_t r;
		n = (vcount == 0) ? 1 : (vcount > NV) ? NV : int'(vcount);
		for (int v = 0; v < n; v++)
			score[v] = 0;
		for (int v = 0; v < n; v++)
			search_from(v, n);
		for (int v = 0; v < n; v++) begin
			r.vid = v[5:0];
			r.cent = score[v];
			r.out_arcs = 0;
			for (int e = 0; e < arcs_held; e++)
				if (arc_from[e] == v && arc_to[e] < n)
					r.out_arcs = 1;
			r.final_vid = (v + 1 == n);
			expected_scores = {expected_scores, r};
		end
		arcs_held = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		vertex_score_t want;
		if (!arst_n) begin
			vcount = bc_pkg::VCOUNT_RESET;
			arcs_held = 0;
			expected_scores.delete();
		end else begin
			if (result_strobe) begin
				if (expected_scores.size() == 0) begin
					report_mismatch($sformatf("unexpected result for vertex %0d", vertex));
				end else begin
					want = expected_scores.pop_front();
					if (vertex !== want.vid)
						report_mismatch($sformatf("vertex %0d, expected %0d",
							vertex, want.vid));
					if (centrality !== want.cent)
						report_mismatch($sformatf("vertex %0d centrality %h, expected %h",
							want.vid, centrality, want.cent));
					if (has_out_edges !== want.out_arcs)
						report_mismatch($sformatf("vertex %0d out-edge flag %b, expected %b",
							want.vid, has_out_edges, want.out_arcs));
					if (last_vertex !== want.final_vid)
						report_mismatch($sformatf("vertex %0d last flag %b, expected %b",
							want.vid, last_vertex, want.final_vid));
				end
			end
			if (cfg_wr_en)
				vcount = cfg_wr_data;
			if (start && !busy) begin
				// full store drops the edge but a last request still computes
				if (arcs_held < NE) begin
					arc_from[arcs_held] = edge_source;
					arc_to[arcs_held] = edge_target;
					arcs_held++;
				end
				if (last_edge)
					predict_scores();
			end
		end
	end

	initial fail_count = 0;

endmodule

FILE: bench/betweenness_centrality_tb.sv
// testbench top: drives edge requests and vertex count settings, gives the verdict
`timescale 1ns / 1ps

module betweenness_centrality_tb;

	// small edge store so that overflowing it stays cheap
	localparam int STORE_DEPTH = 64;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [bc_pkg::CNT_W-1:0]  cfg_wr_data;
	logic                      start;
	logic                      busy;
	logic [bc_pkg::VID_W-1:0]  edge_source;
	logic [bc_pkg::VID_W-1:0]  edge_target;
	logic                      last_edge;
	logic                      result_strobe;
	logic [bc_pkg::VID_W-1:0]  vertex;
	logic [bc_pkg::CENT_W-1:0] centrality;
	logic                      has_out_edges;
	logic                      last_vertex;
	int                        outstanding;
	int                        fail_count;

	int  requests_sent;
	bit  no_gaps;   // stretch with the sender never pausing

	betweenness_centrality #(
		.MAX_EDGES(STORE_DEPTH)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.start(start), .busy(busy),
		.edge_source(edge_source), .edge_target(edge_target), .last_edge(last_edge),
		.result_strobe(result_strobe), .vertex(vertex), .centrality(centrality),
		.has_out_edges(has_out_edges), .last_vertex(last_vertex)
	);

	bc_checker #(
		.MAX_EDGES(STORE_DEPTH)
	) score_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.start(start), .busy(busy),
		.edge_source(edge_source), .edge_target(edge_target), .last_edge(last_edge),
		.result_strobe(result_strobe), .vertex(vertex), .centrality(centrality),
		.has_out_edges(has_out_edges), .last_vertex(last_vertex),
		.outstanding(outstanding), .fail_count(fail_count)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// one edge request; idle gap first, then held until a rising edge sees busy low
	task automatic send_edge(input logic [5:0] s, input logic [5:0] t, input logic fin);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		edge_source <= s;
		edge_target <= t;
		last_edge <= fin;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		requests_sent++;
	endtask

	// hold off until every predicted result has come and the block is idle again
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0 || busy)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_vertex_count(input logic [6:0] cnt);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cnt;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// random graph over vertices below span, with a few endpoints anywhere in range
	task automatic random_graph(input int span, input int arcs);
		logic [5:0] s, t;
		for (int i = 0; i < arcs; i++) begin
			s = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, span - 1));
			t = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, span - 1));
			send_edge(s, t, i == arcs - 1);
		end
	endtask

	initial begin
		int span;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		start = 1'b0;
		edge_source = '0;
		edge_target = '0;
		last_edge = 1'b0;
		requests_sent = 0;
		no_gaps = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset count of 64: a single edge between the two highest ids
		send_edge(6'd62, 6'd63, 1'b1);
		drain();

		// small diamond with a duplicate arc, a self loop and an out-of-range endpoint
		set_vertex_count(7'd5);
		send_edge(6'd0, 6'd1, 1'b0);
		send_edge(6'd0, 6'd2, 1'b0);
		send_edge(6'd1, 6'd3, 1'b0);
		send_edge(6'd2, 6'd3, 1'b0);
		send_edge(6'd2, 6'd3, 1'b0);
		send_edge(6'd3, 6'd3, 1'b0);
		send_edge(6'd3, 6'd4, 1'b0);
		send_edge(6'd4, 6'd63, 1'b0);
		send_edge(6'd63, 6'd0, 1'b1);

		// zero count behaves as one vertex
		set_vertex_count(7'd0);
		send_edge(6'd0, 6'd0, 1'b0);
		send_edge(6'd0, 6'd1, 1'b1);

		// count above the maximum behaves as 64: long directed chain
		set_vertex_count(7'd127);
		no_gaps = 1'b1;
		for (int i = 0; i < 63; i++)
			send_edge(6'(i), 6'(i + 1), i == 62);
		no_gaps = 1'b0;

		// edge store overflow, computed over a single vertex to stay cheap
		set_vertex_count(7'd1);
		no_gaps = 1'b1;
		for (int i = 0; i < STORE_DEPTH + 6; i++)
			send_edge(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
				i == STORE_DEPTH + 5);
		no_gaps = 1'b0;

		// random graphs under a spread of vertex counts, mostly small
		while (requests_sent < 230) begin
			case ($urandom_range(0, 9))
				0: span = 64;
				1: span = 1;
				2: span = 2;
				default: span = $urandom_range(3, 12);
			endcase
			set_vertex_count((span == 64 && $urandom_range(0, 1)) ? 7'd127 : 7'(span));
			no_gaps = ($urandom_range(0, 3) == 0);
			random_graph(span, $urandom_range(1, 14));
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hard limit on the whole run
	initial begin
		#100_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
